@@ hdl/mips_predecode_with_lui_ori_fusion_macros.svh @@
// ----------------------------------------------------------------------------
// mips predecode assertion macros
// implication checks disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef MIPS_PREDECODE_WITH_LUI_ORI_FUSION_MACROS_SVH
`define MIPS_PREDECODE_WITH_LUI_ORI_FUSION_MACROS_SVH

// same-cycle implication
`define MPD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpd_pkg
// classes, kinds, opcode fields and result type of the mips predecoder
// ----------------------------------------------------------------------------
package mpd_pkg;

  typedef enum logic [5:0] {
    C_NOP = 6'd0,
    C_SLL, C_OR, C_SLTU, C_ADDU, C_SLLV, C_AND, C_ADD, C_SUBU, C_SRA,
    C_DIV, C_MFLO, C_SRL, C_DIVU, C_MFHI, C_SLT, C_MTLO, C_MTHI, C_NOR,
    C_SRAV, C_SRLV, C_MULTU, C_XOR, C_MULT, C_SUB, C_JR, C_JALR,
    C_SYSCALL,
    C_BLTZ, C_BGEZ, C_BLTZAL, C_BGEZAL,
    C_MTC0, C_MFC0, C_RFE,
    C_MOVEIMM, C_LUI,
    C_ORI, C_SW, C_ADDIU, C_LHU, C_ADDI, C_LW, C_SH, C_ANDI, C_SB, C_LB,
    C_LBU, C_SLTI, C_SLTIU, C_LH, C_XORI, C_LWL, C_LWR, C_SWL, C_SWR,
    C_J, C_JAL, C_BNE, C_BEQ, C_BGTZ, C_BLEZ
  } op_class_t;

  typedef enum logic [1:0] {
    K_NORMAL  = 2'd0,
    K_BRANCH  = 2'd1,
    K_SYSCALL = 2'd2
  } op_kind_t;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;

  // special funct codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // regimm rt codes
  localparam logic [4:0] RI_BLTZ    = 5'h00;
  localparam logic [4:0] RI_BGEZ    = 5'h01;
  localparam logic [4:0] RI_BLTZAL  = 5'h10;
  localparam logic [4:0] RI_BGEZAL  = 5'h11;

  // cop0 rs codes
  localparam logic [4:0] CO_MFC0    = 5'h00;
  localparam logic [4:0] CO_MTC0    = 5'h04;
  localparam logic [4:0] CO_RFE     = 5'h10;

  localparam logic [4:0] REG_LINK   = 5'd31;

  typedef struct packed {
    op_class_t   op_class;
    op_kind_t    op_kind;
    logic [31:0] regs_used;
    logic        fused;
    logic [31:0] fused_value;
    logic        illegal;
  } result_t;

endpackage

@@ hdl/mpd_if.sv @@
// ----------------------------------------------------------------------------
// mpd channel interfaces
// instruction request channel and predecode result channel
// ----------------------------------------------------------------------------
interface mpd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] next_word;

  modport source (output valid, output instr_word, output next_word, input ready);
  modport sink   (input valid, input instr_word, input next_word, output ready);
endinterface

interface mpd_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  op_class;
  logic [1:0]  op_kind;
  logic [31:0] regs_used;
  logic        fused;
  logic [31:0] fused_value;
  logic        illegal;

  modport source (output valid, output op_class, output op_kind, output regs_used,
                  output fused, output fused_value, output illegal, input ready);
  modport sink   (input valid, input op_class, input op_kind, input regs_used,
                  input fused, input fused_value, input illegal, output ready);
endinterface

@@ hdl/mpd_in_stage.sv @@
// ----------------------------------------------------------------------------
// mpd_in_stage
// input register holding one instruction word pair
// ----------------------------------------------------------------------------
module mpd_in_stage (
  input  logic  clk,
  input  logic  rst_n,
  mpd_in_if.sink in_if,
  input  logic  dn_ready,
  output logic  valid,
  output logic [31:0] instr_word,
  output logic [31:0] next_word
);

  logic        valid_r, valid_nxt;
  logic [31:0] instr_r;
  logic [31:0] next_r;

  // free slot, or the held request moves on this cycle
  assign in_if.ready = !valid_r || dn_ready;
  assign valid_nxt   = in_if.ready ? in_if.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      instr_r <= in_if.instr_word;
      next_r  <= in_if.next_word;
    end
  end

  assign valid      = valid_r;
  assign instr_word = instr_r;
  assign next_word  = next_r;

endmodule

@@ hdl/mpd_decode.sv @@
// ----------------------------------------------------------------------------
// mpd_decode
// combinational predecode of one word with lui/ori fusion
// ----------------------------------------------------------------------------
module mpd_decode (
  input  logic [31:0]     instr_word,
  input  logic [31:0]     next_word,
  output mpd_pkg::result_t res
);
  import mpd_pkg::*;

  logic [5:0]  op;
  logic [4:0]  rs, rt, rd, sa;
  logic [5:0]  fn;
  logic [15:0] imm;
  logic        hit, use_s, use_t, use_d, use_31, fuse;
  op_class_t   cls;
  op_kind_t    kind;

  assign op  = instr_word[31:26];
  assign rs  = instr_word[25:21];
  assign rt  = instr_word[20:16];
  assign rd  = instr_word[15:11];
  assign sa  = instr_word[10:6];
  assign fn  = instr_word[5:0];
  assign imm = instr_word[15:0];

  // ori that writes back into the lui target register
  assign fuse = (next_word[31:26] == OP_ORI) && (next_word[25:21] == rt) &&
                (next_word[20:16] == rt);

  always_comb begin
    hit    = 1'b1;
    cls    = C_NOP;
    kind   = K_NORMAL;
    use_s  = 1'b0;
    use_t  = 1'b0;
    use_d  = 1'b0;
    use_31 = 1'b0;
    unique case (op)
      OP_SPECIAL: begin
        use_s = 1'b1;
        use_t = 1'b1;
        use_d = 1'b1;
        unique case (fn)
          FN_SLL: begin
            if (rt == 5'd0 && rd == 5'd0 && sa == 5'd0) begin
              cls   = C_NOP;
              use_t = 1'b0;
              use_d = 1'b0;
            end else begin
              cls = C_SLL;
            end
            use_s = 1'b0;
          end
          FN_OR:    cls = C_OR;
          FN_SLTU:  cls = C_SLTU;
          FN_ADDU:  cls = C_ADDU;
          FN_SLLV:  cls = C_SLLV;
          FN_AND:   cls = C_AND;
          FN_ADD:   cls = C_ADD;
          FN_SUBU:  cls = C_SUBU;
          FN_SRA:   begin cls = C_SRA; use_s = 1'b0; end
          FN_DIV:   begin cls = C_DIV; use_d = 1'b0; end
          FN_MFLO:  begin cls = C_MFLO; use_s = 1'b0; use_t = 1'b0; end
          FN_SRL:   begin cls = C_SRL; use_s = 1'b0; end
          FN_DIVU:  begin cls = C_DIVU; use_d = 1'b0; end
          FN_MFHI:  begin cls = C_MFHI; use_s = 1'b0; use_t = 1'b0; end
          FN_SLT:   cls = C_SLT;
          FN_MTLO:  begin cls = C_MTLO; use_t = 1'b0; use_d = 1'b0; end
          FN_MTHI:  begin cls = C_MTHI; use_t = 1'b0; use_d = 1'b0; end
          FN_NOR:   cls = C_NOR;
          FN_SRAV:  cls = C_SRAV;
          FN_SRLV:  cls = C_SRLV;
          FN_MULTU: begin cls = C_MULTU; use_d = 1'b0; end
          FN_XOR:   cls = C_XOR;
          FN_MULT:  begin cls = C_MULT; use_d = 1'b0; end
          FN_SUB:   cls = C_SUB;
          FN_JR: begin
            cls   = C_JR;
            kind  = K_BRANCH;
            use_t = 1'b0;
            use_d = 1'b0;
          end
          FN_JALR: begin
            cls   = C_JALR;
            kind  = K_BRANCH;
            use_t = 1'b0;
          end
          FN_SYSCALL: begin
            cls   = C_SYSCALL;
            kind  = K_SYSCALL;
            use_s = 1'b0;
            use_t = 1'b0;
            use_d = 1'b0;
          end
          default: hit = 1'b0;
        endcase
      end
      OP_REGIMM: begin
        kind  = K_BRANCH;
        use_s = 1'b1;
        unique case (rt)
          RI_BLTZ:   cls = C_BLTZ;
          RI_BGEZ:   cls = C_BGEZ;
          RI_BLTZAL: begin cls = C_BLTZAL; use_31 = 1'b1; end
          RI_BGEZAL: begin cls = C_BGEZAL; use_31 = 1'b1; end
          default:   hit = 1'b0;
        endcase
      end
      OP_COP0: begin
        unique case (rs)
          CO_MTC0: begin cls = C_MTC0; use_t = 1'b1; end
          CO_MFC0: begin cls = C_MFC0; use_t = 1'b1; end
          CO_RFE:  cls = C_RFE;
          default: hit = 1'b0;
        endcase
      end
      OP_LUI: begin
        use_t = 1'b1;
        cls   = fuse ? C_MOVEIMM : C_LUI;
      end
      default: begin
        use_s = 1'b1;
        use_t = 1'b1;
        unique case (op)
          OP_ORI:   cls = C_ORI;
          OP_SW:    cls = C_SW;
          OP_ADDIU: cls = C_ADDIU;
          OP_LHU:   cls = C_LHU;
          OP_ADDI:  cls = C_ADDI;
          OP_LW:    cls = C_LW;
          OP_SH:    cls = C_SH;
          OP_ANDI:  cls = C_ANDI;
          OP_SB:    cls = C_SB;
          OP_LB:    cls = C_LB;
          OP_LBU:   cls = C_LBU;
          OP_SLTI:  cls = C_SLTI;
          OP_SLTIU: cls = C_SLTIU;
          OP_LH:    cls = C_LH;
          OP_XORI:  cls = C_XORI;
          OP_LWL:   cls = C_LWL;
          OP_LWR:   cls = C_LWR;
          OP_SWL:   cls = C_SWL;
          OP_SWR:   cls = C_SWR;
          OP_J: begin
            cls   = C_J;
            kind  = K_BRANCH;
            use_s = 1'b0;
            use_t = 1'b0;
          end
          OP_JAL: begin
            cls    = C_JAL;
            kind   = K_BRANCH;
            use_s  = 1'b0;
            use_t  = 1'b0;
            use_31 = 1'b1;
          end
          OP_BNE:  begin cls = C_BNE; kind = K_BRANCH; end
          OP_BEQ:  begin cls = C_BEQ; kind = K_BRANCH; end
          OP_BGTZ: begin cls = C_BGTZ; kind = K_BRANCH; use_t = 1'b0; end
          OP_BLEZ: begin cls = C_BLEZ; kind = K_BRANCH; use_t = 1'b0; end
          default: hit = 1'b0;
        endcase
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (!hit) begin
      res.op_class = C_NOP;
      res.op_kind  = K_NORMAL;
      res.illegal  = 1'b1;
    end else begin
      res.op_class  = cls;
      res.op_kind   = kind;
      res.regs_used = ({32{use_s}}  & (32'd1 << rs)) |
                      ({32{use_t}}  & (32'd1 << rt)) |
                      ({32{use_d}}  & (32'd1 << rd)) |
                      ({32{use_31}} & (32'd1 << REG_LINK));
      if (op == OP_LUI && fuse) begin
        res.fused       = 1'b1;
        res.fused_value = {imm, next_word[15:0]};
      end
    end
  end

endmodule

@@ hdl/mpd_out_stage.sv @@
// ----------------------------------------------------------------------------
// mpd_out_stage
// result register driving the result channel
// ----------------------------------------------------------------------------
module mpd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  mpd_pkg::result_t res,
  mpd_out_if.source        out_if
);
  import mpd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign up_ready  = !valid_r || out_if.ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= res;
    end
  end

  assign out_if.valid       = valid_r;
  assign out_if.op_class    = res_r.op_class;
  assign out_if.op_kind     = res_r.op_kind;
  assign out_if.regs_used   = res_r.regs_used;
  assign out_if.fused       = res_r.fused;
  assign out_if.fused_value = res_r.fused_value;
  assign out_if.illegal     = res_r.illegal;

endmodule

@@ hdl/mips_predecode_with_lui_ori_fusion.sv @@
// ----------------------------------------------------------------------------
// mips_predecode_with_lui_ori_fusion
// mips i predecoder: class, kind, register mask, illegal flag and
// lui/ori fusion into a 32-bit move-immediate
// ----------------------------------------------------------------------------
//
//   channel   direction   payload                                    handshake
//   in_if     sink        instr_word, next_word                      valid/ready
//   out_if    source      op_class, op_kind, regs_used, fused,       valid/ready
//                         fused_value, illegal
//
// one request per cycle sustained while out_if is not stalled; a request
// passes the input register, the decoder and the result register in turn
// synchronous active-low reset empties both registers; payload is not reset
// a stalled result holds while the input register still takes one more
// request; in_if.ready falls only when both registers are full and out_if
// is stalled
//
module mips_predecode_with_lui_ori_fusion (
  input logic       clk,
  input logic       rst_n,
  mpd_in_if.sink    in_if,
  mpd_out_if.source out_if
);
  import mpd_pkg::*;

  // input register outputs
  logic        s1_valid;
  logic        s1_ready;
  logic [31:0] s1_instr;
  logic [31:0] s1_next;

  // decoded result ahead of the result register
  result_t     dec_res;

  // stage 1: capture the word pair
  mpd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .dn_ready   (s1_ready),
    .valid      (s1_valid),
    .instr_word (s1_instr),
    .next_word  (s1_next)
  );

  // classify, build register mask, check for lui followed by matching ori
  mpd_decode u_decode (
    .instr_word (s1_instr),
    .next_word  (s1_next),
    .res        (dec_res)
  );

  // stage 2: hold the result until the consumer takes it
  mpd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .res      (dec_res),
    .out_if   (out_if)
  );

endmodule

@@ hdl/mpd_checker.sv @@
// ----------------------------------------------------------------------------
// mpd_checker
// port-level checks on the predecoder result channel
// ----------------------------------------------------------------------------
`include "mips_predecode_with_lui_ori_fusion_macros.svh"

module mpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_op_class,
  input logic [1:0]  out_op_kind,
  input logic [31:0] out_regs_used,
  input logic        out_fused,
  input logic [31:0] out_fused_value,
  input logic        out_illegal
);
  import mpd_pkg::*;

  // a stalled result stays offered
  `MPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // fusion only ever yields a normal move-immediate
  `MPD_ASSERT_NOW(a_fused_class, clk, rst_n, out_valid && out_fused, out_op_class == C_MOVEIMM && out_op_kind == K_NORMAL && !out_illegal, "fused result with wrong class")

  // an unknown code carries nothing else
  `MPD_ASSERT_NOW(a_illegal_clean, clk, rst_n, out_valid && out_illegal, out_op_class == C_NOP && out_regs_used == 32'd0 && !out_fused && out_fused_value == 32'd0, "illegal result not cleared")

  // no constant without fusion
  `MPD_ASSERT_NOW(a_value_zero, clk, rst_n, out_valid && !out_fused, out_fused_value == 32'd0 && out_op_class != C_MOVEIMM, "constant without fusion")

endmodule

bind mips_predecode_with_lui_ori_fusion mpd_checker u_mpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_op_class    (out_if.op_class),
  .out_op_kind     (out_if.op_kind),
  .out_regs_used   (out_if.regs_used),
  .out_fused       (out_if.fused),
  .out_fused_value (out_if.fused_value),
  .out_illegal     (out_if.illegal)
);
